// File: rtl/bisulfite_trinuc_retention_counter_defines.svh
// assertion macros for the bisulfite trinucleotide retention counter
`ifndef BISULFITE_TRINUC_RETENTION_COUNTER_DEFINES_SVH
`define BISULFITE_TRINUC_RETENTION_COUNTER_DEFINES_SVH
`ifndef SYNTH
`define BTRC_ASSERT_NOW(lbl, en, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (cond)) \
    else $error("btrc assertion failed");
`define BTRC_ASSERT_NEXT(lbl, en, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |=> (cond)) \
    else $error("btrc assertion failed");
`else
`define BTRC_ASSERT_NOW(lbl, en, cond)
`define BTRC_ASSERT_NEXT(lbl, en, cond)
`endif
`endif

// File: rtl/btrc_pkg.sv
// types and codes shared by the retention counter files
`timescale 1ns / 1ps
`default_nettype none
package btrc_pkg;

  localparam logic [2:0] CODE_A = 3'd0;
  localparam logic [2:0] CODE_C = 3'd1;
  localparam logic [2:0] CODE_G = 3'd2;
  localparam logic [2:0] CODE_T = 3'd3;

  localparam logic OP_BASE    = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  localparam logic [1:0] REG_MIN_QUAL  = 2'd0;
  localparam logic [1:0] REG_MIN_END   = 2'd1;
  localparam logic [1:0] REG_MAX_RET   = 2'd2;
  localparam logic [1:0] REG_RELAX     = 2'd3;

  localparam int NUM_CTX = 16;

  typedef struct packed {
    logic       operation;
    logic [4:0] target;
    logic [3:0] context_index;
    logic       strand_minus;
    logic [2:0] ref_left;
    logic [2:0] ref_center;
    logic [2:0] ref_right;
    logic [2:0] called_base;
    logic [6:0] base_quality;
    logic [8:0] read_position;
    logic [9:0] read_length;
    logic       last_in_read;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        read_kept;
    logic        final_strand_minus;
    logic [31:0] total_count;
    logic [31:0] retained_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [19:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [2:0] left;
    logic [2:0] center;
    logic [2:0] right;
    logic [2:0] called;
    logic [6:0] qual;
    logic [8:0] pos;
  } site_t;

endpackage
`default_nettype wire

// File: rtl/btrc_stream_if.sv
// valid/ready channel carrying one payload type
`timescale 1ns / 1ps
`default_nettype none
interface btrc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/btrc_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module btrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// File: rtl/bisulfite_trinuc_retention_counter.sv
// top level of the bisulfite trinucleotide retention counter
//
//  channel | dir | payload      | transaction
//  in_ch   | in  | in_item_t    | one aligned base or one counter readout request
//  out_ch  | out | out_item_t   | one read summary or one counter readout
//  cfg_ch  | in  | cfg_item_t   | one register write, always ready
//
// a non-final base is written through the buffer ram write port; the last base of a dropped read starts no walk
// the last base of a counted read starts a walk over the buffered bases: S_WSTART, then S_EVAL per base,
//   and a counted base adds S_UPD (counter ram read in S_EVAL, then write back in S_UPD)
// a readout reads the counter ram in S_IDLE and registers the result in S_RDOUT
// after reset a clearing pass zeroes all NUM_TARGETS*16 entries of the counter ram
// input is held off while the output register holds an untaken result
`timescale 1ns / 1ps
`default_nettype none
`include "bisulfite_trinuc_retention_counter_defines.svh"
module bisulfite_trinuc_retention_counter #(
  parameter int MAX_READ_LEN  = 512,
  parameter int NUM_TARGETS   = 32,
  parameter int COUNTER_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  btrc_stream_if.sink   in_ch,
  btrc_stream_if.source out_ch,
  btrc_stream_if.sink   cfg_ch
);
  localparam int FW   = $clog2(MAX_READ_LEN + 1);  // fill count width
  localparam int BW   = $clog2(MAX_READ_LEN);      // buffer address width
  localparam int CD   = NUM_TARGETS * btrc_pkg::NUM_CTX;
  localparam int CAW  = $clog2(CD);
  localparam int CW   = COUNTER_WIDTH;
  localparam int SW   = $bits(btrc_pkg::site_t);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RDOUT  = 3'd2;
  localparam logic [2:0] S_WSTART = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;
  localparam logic [2:0] S_UPD    = 3'd5;

  logic [2:0] state_r;

  // configuration registers
  logic [6:0]  min_qual_r;
  logic [7:0]  min_end_r;
  logic [19:0] max_ret_r;
  logic        relax_r;

  // read profile
  logic [FW-1:0] fill_r, ct_r, ga_r, ret_r;
  logic [FW-1:0] fill_nxt, ct_nxt, ga_nxt, ret_nxt;

  // walk context
  logic [FW-1:0]  k_r, walk_len_r;
  logic           minus_r;
  logic [4:0]     tgt_r;
  logic [9:0]     len_r;
  logic           hit_r;
  logic [CAW-1:0] ctr_addr_r;
  logic [CAW-1:0] clr_addr_r;
  logic           rd_zero_r;

  logic                   out_valid_r;
  btrc_pkg::out_item_t    out_data_r;

  btrc_pkg::in_item_t d;
  assign d = in_ch.data;

  logic in_fire;
  logic rdout_req;
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign rdout_req   = in_fire && (d.operation == btrc_pkg::OP_READOUT);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  logic is_base, store_base;
  assign is_base    = in_fire && (d.operation == btrc_pkg::OP_BASE);
  assign store_base = is_base && (fill_r < FW'(MAX_READ_LEN));

  // profile next values, including the base being taken now
  always_comb begin
    fill_nxt = fill_r;
    ct_nxt   = ct_r;
    ga_nxt   = ga_r;
    ret_nxt  = ret_r;
    if (store_base) begin
      fill_nxt = fill_r + FW'(1);
      if (d.ref_center == btrc_pkg::CODE_C && d.called_base == btrc_pkg::CODE_T)
        ct_nxt = ct_r + FW'(1);
      if (d.ref_center == btrc_pkg::CODE_G && d.called_base == btrc_pkg::CODE_A)
        ga_nxt = ga_r + FW'(1);
      if ((!d.strand_minus && d.ref_center == btrc_pkg::CODE_C &&
           d.called_base == btrc_pkg::CODE_C) ||
          (d.strand_minus && d.ref_center == btrc_pkg::CODE_G &&
           d.called_base == btrc_pkg::CODE_G))
        ret_nxt = ret_r + FW'(1);
    end
  end

  // end-of-read decision
  logic kept, fin_minus, in_tgt_ok;
  always_comb begin
    kept      = 1'b1;
    fin_minus = d.strand_minus;
    if (!relax_r) begin
      if (ct_nxt != '0 && ga_nxt != '0) begin
        kept = 1'b0;
      end else begin
        if (ct_nxt != '0 && fin_minus) fin_minus = 1'b0;
        if (ga_nxt != '0 && !fin_minus) fin_minus = 1'b1;
      end
    end
    if (32'(ret_nxt) >= 32'(max_ret_r)) kept = 1'b0;
  end
  assign in_tgt_ok = 32'(d.target) < NUM_TARGETS;

  // buffer ram
  btrc_pkg::site_t wr_site, rd_site;
  logic [SW-1:0]   buf_q;
  logic            buf_rd_en;
  logic [BW-1:0]   buf_rd_addr;
  assign wr_site = '{left: d.ref_left, center: d.ref_center, right: d.ref_right,
                     called: d.called_base, qual: d.base_quality,
                     pos: d.read_position};
  assign rd_site = btrc_pkg::site_t'(buf_q);

  btrc_ram #(.WIDTH(SW), .DEPTH(MAX_READ_LEN)) u_buf_ram (
    .clk     (clk),
    .wr_en   (store_base),
    .wr_addr (fill_r[BW-1:0]),
    .wr_data (wr_site),
    .rd_en   (buf_rd_en),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_q)
  );

  // site evaluation on the buffered base
  logic       skip, is_c, is_g, counted, hit;
  logic [3:0] ctx;
  logic [9:0] end_gap;
  always_comb begin
    end_gap = len_r - {1'b0, rd_site.pos};
    skip = ({1'b0, rd_site.pos} <= {2'b0, min_end_r}) ||
           ((10'(rd_site.pos) <= len_r) && (end_gap <= {2'b0, min_end_r})) ||
           (rd_site.qual <= min_qual_r) ||
           rd_site.left[2] || rd_site.center[2] || rd_site.right[2];
    is_c = !minus_r && rd_site.center == btrc_pkg::CODE_C;
    is_g = minus_r && rd_site.center == btrc_pkg::CODE_G;
    counted = !skip && (is_c || is_g);
    // minus strand context is taken from the complemented, swapped flanks
    ctx = is_c ? {rd_site.left[1:0], rd_site.right[1:0]}
               : {~rd_site.right[1:0], ~rd_site.left[1:0]};
    hit = is_c ? (rd_site.called == btrc_pkg::CODE_C)
               : (rd_site.called == btrc_pkg::CODE_G);
  end

  logic walk_last;
  assign walk_last = (k_r + FW'(1)) == walk_len_r;

  // counter ram: retained in the upper half, total in the lower half
  logic [2*CW-1:0] ctr_q, ctr_wdata;
  logic            ctr_rd_en, ctr_wr_en;
  logic [CAW-1:0]  ctr_rd_addr, ctr_wr_addr;
  logic [CW-1:0]   tot_q, rtn_q, tot_inc, rtn_inc;
  assign tot_q   = ctr_q[CW-1:0];
  assign rtn_q   = ctr_q[2*CW-1:CW];
  assign tot_inc = (&tot_q) ? tot_q : tot_q + CW'(1);   // saturate
  assign rtn_inc = (hit_r && !(&rtn_q)) ? rtn_q + CW'(1) : rtn_q;

  always_comb begin
    ctr_rd_en   = 1'b0;
    ctr_rd_addr = CAW'({d.target, d.context_index});
    ctr_wr_en   = 1'b0;
    ctr_wr_addr = ctr_addr_r;
    ctr_wdata   = {rtn_inc, tot_inc};
    buf_rd_en   = 1'b0;
    buf_rd_addr = (k_r[BW-1:0] + BW'(1));
    unique case (state_r)
      S_CLEAR: begin
        ctr_wr_en   = 1'b1;
        ctr_wr_addr = clr_addr_r;
        ctr_wdata   = '0;
      end
      S_IDLE: begin
        ctr_rd_en = rdout_req;
      end
      S_WSTART: begin
        buf_rd_en   = 1'b1;
        buf_rd_addr = '0;
      end
      S_EVAL: begin
        ctr_rd_en   = counted;
        ctr_rd_addr = CAW'({tgt_r, ctx});
        buf_rd_en   = !counted && !walk_last;
      end
      S_UPD: begin
        ctr_wr_en = 1'b1;
        buf_rd_en = !walk_last;
      end
      default: begin
      end
    endcase
  end

  btrc_ram #(.WIDTH(2 * CW), .DEPTH(CD)) u_ctr_ram (
    .clk     (clk),
    .wr_en   (ctr_wr_en),
    .wr_addr (ctr_wr_addr),
    .wr_data (ctr_wdata),
    .rd_en   (ctr_rd_en),
    .rd_addr (ctr_rd_addr),
    .rd_data (ctr_q)
  );

  // low 32 bits of each counter for readout
  logic [CW+31:0] tot_ext, rtn_ext;
  assign tot_ext = {32'b0, tot_q};
  assign rtn_ext = {32'b0, rtn_q};

  btrc_pkg::cfg_item_t c;
  assign c = cfg_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      min_qual_r  <= 7'd10;
      min_end_r   <= 8'd2;
      max_ret_r   <= 20'd999999;
      relax_r     <= 1'b0;
      fill_r      <= '0;
      ct_r        <= '0;
      ga_r        <= '0;
      ret_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (c.index)
          btrc_pkg::REG_MIN_QUAL: min_qual_r <= c.data[6:0];
          btrc_pkg::REG_MIN_END:  min_end_r  <= c.data[7:0];
          btrc_pkg::REG_MAX_RET:  max_ret_r  <= c.data;
          btrc_pkg::REG_RELAX:    relax_r    <= c.data[0];
        endcase
      end
      if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + CAW'(1);
          if (clr_addr_r == CAW'(CD - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (rdout_req) begin
            rd_zero_r <= !in_tgt_ok;
            state_r   <= S_RDOUT;
          end else if (is_base) begin
            fill_r <= fill_nxt;
            ct_r   <= ct_nxt;
            ga_r   <= ga_nxt;
            ret_r  <= ret_nxt;
            if (d.last_in_read) begin
              fill_r <= '0;
              ct_r   <= '0;
              ga_r   <= '0;
              ret_r  <= '0;
              out_valid_r <= 1'b1;
              out_data_r  <= '{result_kind: btrc_pkg::KIND_SUMMARY, read_kept: kept,
                               final_strand_minus: fin_minus, total_count: 32'd0,
                               retained_count: 32'd0};
              minus_r    <= fin_minus;
              tgt_r      <= d.target;
              len_r      <= d.read_length;
              walk_len_r <= fill_nxt;
              k_r        <= '0;
              if (kept && in_tgt_ok) state_r <= S_WSTART;
            end
          end
        end
        S_RDOUT: begin
          out_valid_r <= 1'b1;
          out_data_r  <= '{result_kind: btrc_pkg::KIND_READOUT, read_kept: 1'b0,
                           final_strand_minus: 1'b0,
                           total_count: rd_zero_r ? 32'd0 : tot_ext[31:0],
                           retained_count: rd_zero_r ? 32'd0 : rtn_ext[31:0]};
          state_r <= S_IDLE;
        end
        S_WSTART: state_r <= S_EVAL;
        S_EVAL: begin
          if (counted) begin
            hit_r      <= hit;
            ctr_addr_r <= ctr_rd_addr;
            state_r    <= S_UPD;
          end else if (walk_last) begin
            state_r <= S_IDLE;
          end else begin
            k_r <= k_r + FW'(1);
          end
        end
        S_UPD: begin
          if (walk_last) begin
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + FW'(1);
            state_r <= S_EVAL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  `BTRC_ASSERT_NOW(a_ready_idle, in_ch.ready, state_r == S_IDLE)
  `BTRC_ASSERT_NOW(a_walk_in_range, state_r == S_EVAL, k_r < walk_len_r)
  `BTRC_ASSERT_NEXT(a_readout_next, rdout_req, state_r == S_RDOUT)
  `BTRC_ASSERT_NEXT(a_upd_once, state_r == S_UPD, state_r != S_UPD)
endmodule
`default_nettype wire
